// ----- rtl/wheel_speed_smoother_macros.svh -----
// ---------------------------------------------------------------------------
// wheel_speed_smoother_macros.svh
// Assertion macros used by the port checker of the wheel speed smoother.
// ---------------------------------------------------------------------------
`ifndef WHEEL_SPEED_SMOOTHER_MACROS_SVH
`define WHEEL_SPEED_SMOOTHER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define WSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wheel_speed_smoother assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define WSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wheel_speed_smoother assertion failed");

`endif

// ----- rtl/wss_pkg.sv -----
// ---------------------------------------------------------------------------
// wss_pkg
// Types, constants and codes shared by the wheel speed smoother modules.
// ---------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam int NUM_ROBOTS  = 3;
    localparam int WHEELS      = 2 * NUM_ROBOTS;
    localparam int WHEEL_W     = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    localparam int ROBOT_ID_W  = 2;
    localparam int PWM_W       = 8;
    localparam int MAX_SPEED_W = 10;
    localparam int GAIN_W      = 17;
    localparam int DEADBAND_W  = 26;
    localparam int TARGET_W    = 11;
    localparam int SPEED_W     = 27;
    localparam int FRAC_W      = 16;

    localparam int SPEED_LIMIT = 67043328;

    // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for x < 267365,
    // which covers every max_speed * pwm product
    localparam int SCALED_W    = MAX_SPEED_W + PWM_W;
    localparam int RECIP_255_W = 19;
    localparam logic [RECIP_255_W-1:0] RECIP_255 = 19'h40405;
    localparam int RECIP_SHIFT = 26;

    localparam int IN_DATA_W   = 24;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_TICK = 2'd1,
        OP_STOP = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        REG_MAX_SPEED = 2'd0,
        REG_GAIN      = 2'd1,
        REG_DEADBAND  = 2'd2,
        REG_TEAM      = 2'd3
    } reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic               load_in;   // capture set-item fields, form PWM products
        logic               clear;     // stop: zero all targets and speeds
        logic               set_wr;    // write the two targets of one robot
        logic               tick_mul;  // form (target - v) * gain for one wheel
        logic               tick_upd;  // finish and write back one wheel
        logic               emit;      // load the output register
        logic [WHEEL_W-1:0] wheel;
    } wss_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } wss_stat_t;

endpackage

`default_nettype wire

// ----- rtl/wss_ctrl.sv -----
// ---------------------------------------------------------------------------
// wss_ctrl
// Sequencer: decodes input beats and steps the datapath through the wheels.
// ---------------------------------------------------------------------------
`default_nettype none

module wss_ctrl
    import wss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_USER_W-1:0]  opcode,
    input  wire logic [ROBOT_ID_W-1:0] robot_index,
    input  wire wss_stat_t             stat,
    output wss_cmd_t                   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET,
        ST_MUL,
        ST_UPD
    } state_t;

    localparam logic [WHEEL_W-1:0] LAST_WHEEL = WHEEL_W'(WHEELS - 1);

    state_t             state_reg;
    logic [WHEEL_W-1:0] wheel_reg;
    logic               ready_reg;
    logic               accept;
    logic               upd_go;

    assign accept = (state_reg == ST_IDLE) && s_axis_tvalid && ready_reg;
    // the right wheel closes a robot and needs a free output slot
    assign upd_go = (state_reg == ST_UPD) && (!wheel_reg[0] || stat.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wheel_reg <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (opcode_t'(opcode))
                            OP_SET:
                            begin
                                if (32'(robot_index) < NUM_ROBOTS)
                                begin
                                    state_reg <= ST_SET;
                                    ready_reg <= 1'b0;
                                end
                            end
                            OP_TICK:
                            begin
                                state_reg <= ST_MUL;
                                wheel_reg <= '0;
                                ready_reg <= 1'b0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SET:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
                ST_MUL:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (upd_go)
                    begin
                        if (wheel_reg == LAST_WHEEL)
                        begin
                            state_reg <= ST_IDLE;
                            ready_reg <= 1'b1;
                        end
                        else
                        begin
                            wheel_reg <= wheel_reg + 1'b1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_axis_tready = ready_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load_in  = accept;
        cmd.clear    = accept && (opcode_t'(opcode) == OP_STOP);
        cmd.set_wr   = (state_reg == ST_SET);
        cmd.tick_mul = (state_reg == ST_MUL);
        cmd.tick_upd = upd_go;
        cmd.emit     = upd_go && wheel_reg[0];
        cmd.wheel    = wheel_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/wss_datapath.sv -----
// ---------------------------------------------------------------------------
// wss_datapath
// Target/speed store, shared smoothing multiplier and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module wss_datapath
    import wss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wss_cmd_t               cmd,
    output wss_stat_t                   stat,
    input  wire logic [MAX_SPEED_W-1:0] max_speed,
    input  wire logic [GAIN_W-1:0]      smoothing_gain,
    input  wire logic [DEADBAND_W-1:0]  deadband,
    input  wire logic                   yellow_team,
    input  wire logic [ROBOT_ID_W-1:0]  robot_index,
    input  wire logic [PWM_W-1:0]       pwm_left,
    input  wire logic [PWM_W-1:0]       pwm_right,
    input  wire logic                   reverse_left,
    input  wire logic                   reverse_right,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int RECIP_W = SCALED_W + RECIP_255_W;
    localparam int DIFF_W  = SPEED_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int DELTA_W = PROD_W - FRAC_W;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int PAD_W   = OUT_DATA_W - ROBOT_ID_W - 2 * SPEED_W - 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(SPEED_LIMIT);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(SPEED_LIMIT);

    function automatic logic signed [TARGET_W-1:0] to_target(
        input logic [SCALED_W-1:0] scaled,
        input logic                rev
    );
        logic [RECIP_W-1:0]          full;
        logic signed [TARGET_W-1:0]  mag;
        full = RECIP_W'(scaled) * RECIP_W'(RECIP_255);
        mag  = TARGET_W'(full >> RECIP_SHIFT);
        return rev ? -mag : mag;
    endfunction

    // state
    logic signed [TARGET_W-1:0] target_reg [WHEELS];
    logic signed [SPEED_W-1:0]  speed_reg  [WHEELS];

    // set path
    logic [ROBOT_ID_W-1:0] idx_reg;
    logic                  rev_l_reg;
    logic                  rev_r_reg;
    logic [SCALED_W-1:0]   scaled_l_reg;
    logic [SCALED_W-1:0]   scaled_r_reg;
    logic [WHEEL_W-1:0]    set_wheel;
    logic signed [TARGET_W-1:0] new_l;
    logic signed [TARGET_W-1:0] new_r;

    // tick path
    logic signed [TARGET_W-1:0] rd_target;
    logic signed [SPEED_W-1:0]  rd_speed;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SPEED_W-1:0]  v_reg;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SPEED_W-1:0]  sat;
    logic signed [SPEED_W-1:0]  db_pos;
    logic signed [SPEED_W-1:0]  db_neg;
    logic signed [SPEED_W-1:0]  upd_speed;
    logic signed [SPEED_W-1:0]  left_hold_reg;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    assign set_wheel = WHEEL_W'({idx_reg, 1'b0});
    assign new_l     = to_target(scaled_l_reg, rev_l_reg);
    assign new_r     = to_target(scaled_r_reg, rev_r_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            idx_reg      <= robot_index;
            rev_l_reg    <= reverse_left;
            rev_r_reg    <= reverse_right;
            scaled_l_reg <= SCALED_W'(max_speed) * SCALED_W'(pwm_left);
            scaled_r_reg <= SCALED_W'(max_speed) * SCALED_W'(pwm_right);
        end
    end

    // (target << 16) - v, times the gain; registered before the update
    assign rd_target = target_reg[cmd.wheel];
    assign rd_speed  = speed_reg[cmd.wheel];
    assign diff      = (DIFF_W'(rd_target) <<< FRAC_W) - DIFF_W'(rd_speed);
    assign prod      = PROD_W'(diff) * PROD_W'($signed({1'b0, smoothing_gain}));

    always_ff @(posedge clk)
    begin
        if (cmd.tick_mul)
        begin
            prod_reg <= prod;
            v_reg    <= rd_speed;
        end
    end

    // arithmetic shift is the floor of the division by 2^16
    assign delta  = prod_reg[PROD_W-1:FRAC_W];
    assign sum    = SUM_W'(v_reg) + SUM_W'(delta);
    assign db_pos = $signed({1'b0, deadband});
    assign db_neg = -db_pos;

    always_comb
    begin
        if (sum > SUM_MAX)
            sat = SPEED_W'(SUM_MAX);
        else if (sum < SUM_MIN)
            sat = SPEED_W'(SUM_MIN);
        else
            sat = SPEED_W'(sum);

        if ((!sat[SPEED_W-1] && sat < db_pos) || (sat[SPEED_W-1] && sat > db_neg))
            upd_speed = '0;
        else
            upd_speed = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                target_reg[i] <= '0;
                speed_reg[i]  <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                target_reg[i] <= '0;
                speed_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                if (cmd.set_wr && WHEEL_W'(i) == set_wheel)
                    target_reg[i] <= new_l;
                if (cmd.set_wr && WHEEL_W'(i) == (set_wheel | WHEEL_W'(1)))
                    target_reg[i] <= new_r;
                if (cmd.tick_upd && WHEEL_W'(i) == cmd.wheel)
                    speed_reg[i] <= upd_speed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_upd && !cmd.wheel[0])
            left_hold_reg <= upd_speed;
        if (cmd.emit)
        begin
            out_data_reg <= {PAD_W'(0), yellow_team, upd_speed, left_hold_reg,
                             ROBOT_ID_W'(cmd.wheel >> 1)};
            out_last_reg <= (cmd.wheel == WHEEL_W'(WHEELS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign stat.out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/wheel_speed_smoother.sv -----
// ---------------------------------------------------------------------------
// wheel_speed_smoother
// Wheel targets and exponential smoothing with deadband for a robot team.
// ---------------------------------------------------------------------------
// Usage:
//  - Input beats (s_axis_*): tuser carries the opcode (set, tick, stop).
//    A set beat stores one robot's two wheel targets from PWM and reverse
//    bits; a stop beat zeroes all targets and speeds; a tick beat smooths
//    all 2*NUM_ROBOTS wheels and returns one beat per robot.
//  - Output beats (m_axis_*): one per robot in robot order, tlast on the
//    last robot of a tick.
//  - Sequencing: a stop is taken while the block stays idle; a set goes
//    through the PWM product, then the reciprocal multiply by 1/255 and
//    the write. A tick steps each wheel through a multiply and an update
//    on one shared multiplier, then returns to idle to take the next beat.
//  - Output order: a robot's beat is loaded when its right wheel is
//    updated, after the multiply and update of both its wheels.
//  - Stall: the output holds one beat; while it is not taken the tick
//    pauses before loading the next robot. The input stays ready after a
//    tick ends even if the last beat is still waiting.
//  - Reset: registers return to defaults, all speeds and targets are zero.
//  - Config (APB, 4-byte stride): max_speed, smoothing_gain, deadband,
//    yellow_team; write only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module wheel_speed_smoother
    import wss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready,

    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // robot_index[1:0], pwm_left[9:2], pwm_right[17:10],
    // reverse_left[18], reverse_right[19], zero pad [23:20]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,

    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // robot_id[1:0], left_speed[28:2], right_speed[55:29],
    // team_flag[56], zero pad [63:57]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    logic [MAX_SPEED_W-1:0] max_speed_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [DEADBAND_W-1:0]  deadband_reg;
    logic                   team_reg;
    logic                   cfg_wr;
    reg_idx_t               cfg_idx;

    wss_cmd_t               cmd;
    wss_stat_t              stat;

    // register file: word index from paddr[3:2]
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_W'(100);
            gain_reg      <= GAIN_W'(32768);
            deadband_reg  <= '0;
            team_reg      <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAX_SPEED: max_speed_reg <= pwdata[MAX_SPEED_W-1:0];
                REG_GAIN:      gain_reg      <= pwdata[GAIN_W-1:0];
                REG_DEADBAND:  deadband_reg  <= pwdata[DEADBAND_W-1:0];
                REG_TEAM:      team_reg      <= pwdata[0];
                default:       team_reg      <= team_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MAX_SPEED: prdata = CFG_DATA_W'(max_speed_reg);
            REG_GAIN:      prdata = CFG_DATA_W'(gain_reg);
            REG_DEADBAND:  prdata = CFG_DATA_W'(deadband_reg);
            REG_TEAM:      prdata = CFG_DATA_W'(team_reg);
            default:       prdata = '0;
        endcase
    end

    // sequencer: beat decode and the per-wheel stepping of a tick
    wss_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .opcode        (s_axis_tuser),
        .robot_index   (s_axis_tdata[1:0]),
        .stat          (stat),
        .cmd           (cmd)
    );

    // state store, shared multiplier and output register
    wss_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .max_speed      (max_speed_reg),
        .smoothing_gain (gain_reg),
        .deadband       (deadband_reg),
        .yellow_team    (team_reg),
        .robot_index    (s_axis_tdata[1:0]),
        .pwm_left       (s_axis_tdata[9:2]),
        .pwm_right      (s_axis_tdata[17:10]),
        .reverse_left   (s_axis_tdata[18]),
        .reverse_right  (s_axis_tdata[19]),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/wss_checker.sv -----
// ---------------------------------------------------------------------------
// wss_port_checker
// Port-level assertions for the wheel speed smoother, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "wheel_speed_smoother_macros.svh"

module wss_port_checker
    import wss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tlast
);

    // stalled output beat holds
    `WSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // tlast marks exactly the highest robot
    `WSS_ASSERT_NOW(a_last_robot, m_axis_tvalid,
        m_axis_tlast == (32'(m_axis_tdata[1:0]) == NUM_ROBOTS - 1))

    // speeds stay inside the saturation range
    `WSS_ASSERT_NOW(a_speed_range, m_axis_tvalid,
        $signed(m_axis_tdata[28:2]) <= SPEED_LIMIT &&
        $signed(m_axis_tdata[28:2]) >= -SPEED_LIMIT &&
        $signed(m_axis_tdata[55:29]) <= SPEED_LIMIT &&
        $signed(m_axis_tdata[55:29]) >= -SPEED_LIMIT)

    // a tick occupies the block: input not ready the next cycle
    `WSS_ASSERT_NEXT(a_tick_busy,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TICK,
        !s_axis_tready)

endmodule

bind wheel_speed_smoother wss_port_checker u_wss_checker (.*);

`default_nettype wire

// ----- sim/wss_checker.sv -----
// ---------------------------------------------------------------------------
// wss_checker
// Watches the config port and both streams of the wheel speed smoother,
// predicts each robot command from its own copy of targets and speeds, and
// compares the commands field by field against the DUT's output beats.
// ---------------------------------------------------------------------------
module wss_checker
    import wss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  end_of_test,
    output int                    fail_count,
    output int                    pending_cmds,
    output int                    ticks_seen,
    output int                    cmds_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEFT_LSB  = ROBOT_ID_W;
    localparam int RIGHT_LSB = LEFT_LSB + SPEED_W;
    localparam int TEAM_BIT  = RIGHT_LSB + SPEED_W;

    typedef struct {
        logic [ROBOT_ID_W-1:0]     robot;
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
        logic                      team;
        logic                      last;
    } robot_cmd_t;

    longint     max_speed_q;
    longint     gain_q;
    longint     deadband_q;
    logic       team_q;
    longint     wheel_tgt [WHEELS];
    longint     wheel_spd [WHEELS];
    robot_cmd_t cmd_q [$];
    bit         end_seen;

    // floor(max_speed * pwm / 255), negated on reverse
    function automatic longint wheel_target(logic [PWM_W-1:0] pwm, logic rev);
        longint t;
        t = (max_speed_q * longint'(pwm)) / 255;
        return rev ? -t : t;
    endfunction

    // one smoothing step: arithmetic floor shift, saturate, then deadband
    function automatic longint smooth_wheel(longint v, longint tgt);
        longint nxt;
        nxt = v + ((((tgt <<< FRAC_W) - v) * gain_q) >>> FRAC_W);
        if (nxt > SPEED_LIMIT)
            nxt = SPEED_LIMIT;
        if (nxt < -SPEED_LIMIT)
            nxt = -SPEED_LIMIT;
        if ((nxt < 0 ? -nxt : nxt) < deadband_q)
            nxt = 0;
        return nxt;
    endfunction

    function automatic int field_bad(string name, longint want, longint got);
        if (want == got)
            return 0;
        $display("%0t: robot command %s mismatch, expected %0d, got %0d",
                 $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        robot_cmd_t want;
        robot_cmd_t got;
        logic [1:0] idx;
        if (!rst_n)
        begin
            max_speed_q = 100;
            gain_q      = 32768;
            deadband_q  = 0;
            team_q      = 1'b0;
            for (int w = 0; w < WHEELS; w++)
            begin
                wheel_tgt[w] = 0;
                wheel_spd[w] = 0;
            end
            cmd_q.delete();
            end_seen     = 1'b0;
            fail_count   = 0;
            ticks_seen   = 0;
            cmds_checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_MAX_SPEED: max_speed_q = longint'(pwdata[MAX_SPEED_W-1:0]);
                    REG_GAIN:      gain_q      = longint'(pwdata[GAIN_W-1:0]);
                    REG_DEADBAND:  deadband_q  = longint'(pwdata[DEADBAND_W-1:0]);
                    REG_TEAM:      team_q      = pwdata[0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.robot = m_axis_tdata[ROBOT_ID_W-1:0];
                got.left  = m_axis_tdata[LEFT_LSB +: SPEED_W];
                got.right = m_axis_tdata[RIGHT_LSB +: SPEED_W];
                got.team  = m_axis_tdata[TEAM_BIT];
                got.last  = m_axis_tlast;
                if (cmd_q.size() == 0)
                begin
                    $display("%0t: robot command with none expected, expected none, got robot %0d",
                             $time, got.robot);
                    fail_count++;
                end
                else
                begin
                    want = cmd_q.pop_front();
                    fail_count += field_bad("robot_id", want.robot, got.robot);
                    fail_count += field_bad("left_speed", want.left, got.left);
                    fail_count += field_bad("right_speed", want.right, got.right);
                    fail_count += field_bad("team_flag", want.team, got.team);
                    fail_count += field_bad("last_robot", want.last, got.last);
                    cmds_checked++;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                idx = s_axis_tdata[1:0];
                case (opcode_t'(s_axis_tuser))
                    OP_SET:
                        if (idx < NUM_ROBOTS)
                        begin
                            wheel_tgt[2*idx]   = wheel_target(s_axis_tdata[9:2], s_axis_tdata[18]);
                            wheel_tgt[2*idx+1] = wheel_target(s_axis_tdata[17:10], s_axis_tdata[19]);
                        end
                    OP_STOP:
                        for (int w = 0; w < WHEELS; w++)
                        begin
                            wheel_tgt[w] = 0;
                            wheel_spd[w] = 0;
                        end
                    OP_TICK:
                    begin
                        ticks_seen++;
                        for (int w = 0; w < WHEELS; w++)
                            wheel_spd[w] = smooth_wheel(wheel_spd[w], wheel_tgt[w]);
                        for (int r = 0; r < NUM_ROBOTS; r++)
                        begin
                            want.robot = ROBOT_ID_W'(r);
                            want.left  = wheel_spd[2*r][SPEED_W-1:0];
                            want.right = wheel_spd[2*r+1][SPEED_W-1:0];
                            want.team  = team_q;
                            want.last  = (r == NUM_ROBOTS - 1);
                            cmd_q.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end

            if (end_of_test && !end_seen)
            begin
                end_seen = 1'b1;
                if (cmd_q.size() != 0)
                    $display("%0t: robot commands never seen, expected %0d, got 0",
                             $time, cmd_q.size());
                fail_count += cmd_q.size();
            end
            pending_cmds = cmd_q.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the wheel speed smoother.
// A directed pass covers PWM and speed extremes, reverse, ignored beats,
// stop and the deadband boundary; six register settings then run random
// set/tick/stop traffic with random idling on both streams, a long output
// hold-off and a full drain in the middle. Checking lives in wss_checker.
// ---------------------------------------------------------------------------
module tb_top;

    import wss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED    = 2'd3;  // not decoded, dropped by the DUT
    localparam int HOLD_CYCLES          = 400;   // long output back-pressure
    localparam int IDLE_GAP             = 20;    // covers a set's tail before a reg write
    localparam int PHASES               = 6;
    localparam int ITEMS_PER_PHASE      = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // robot_index, pwm_left, pwm_right, rev_l, rev_r
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // robot_id, left, right, team_flag
    logic                  m_axis_tlast;

    logic end_of_test = 1'b0;
    int   fail_count;
    int   pending_cmds;
    int   ticks_seen;
    int   cmds_checked;

    // receiver control: stimulus bumps hold_reqs, receiver counts the hold itself
    bit   calm = 1'b0;
    int   hold_reqs = 0;
    int   hold_done = 0;
    int   hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    wheel_speed_smoother u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    wss_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .end_of_test   (end_of_test),
        .fail_count    (fail_count),
        .pending_cmds  (pending_cmds),
        .ticks_seen    (ticks_seen),
        .cmds_checked  (cmds_checked)
    );

    // Output side: ~10% random stalls, none while calm, and a long
    // hold-off whenever the stimulus asks for one.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_reqs != hold_done)
        begin
            hold_done     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 10);
    end

    // Setup then access phase; pready is sampled on the access edge.
    task automatic apb_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(int max_spd, int gain, int dband, bit team);
        apb_write(REG_MAX_SPEED, CFG_DATA_W'(max_spd));
        apb_write(REG_GAIN, CFG_DATA_W'(gain));
        apb_write(REG_DEADBAND, CFG_DATA_W'(dband));
        apb_write(REG_TEAM, CFG_DATA_W'(team));
    endtask

    // One input beat. A random gap (valid low) may come first; valid then
    // stays up until the beat is taken. Gaps up to a full tick's length so
    // they land on every stage of the tick sequence.
    task automatic send_beat(logic [1:0] op, logic [1:0] idx, logic [PWM_W-1:0] pwm_l,
                             logic [PWM_W-1:0] pwm_r, logic rev_l, logic rev_r);
        int gap;
        gap = (!calm && $urandom_range(99) < 10) ? $urandom_range(1, 14) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, rev_r, rev_l, pwm_r, pwm_l, idx};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid, let every outstanding command drain, then let the block
    // finish any set still in flight.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_cmds != 0)
            @(negedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // Extremes show up a quarter of the time.
    function automatic logic [PWM_W-1:0] rand_pwm();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return PWM_W'($urandom_range(255));
    endfunction

    // Mostly sets and ticks; stops clear state now and then. Out-of-range
    // robots and the unused opcode are noise and do not count.
    task automatic random_item(output bit counted);
        int pick;
        pick    = $urandom_range(99);
        counted = 1'b1;
        if (pick < 50)
            send_beat(OP_SET, 2'($urandom_range(NUM_ROBOTS - 1)), rand_pwm(), rand_pwm(),
                      1'($urandom), 1'($urandom));
        else if (pick < 55)
        begin
            counted = 1'b0;
            send_beat(OP_SET, 2'd3, rand_pwm(), rand_pwm(), 1'($urandom), 1'($urandom));
        end
        else if (pick < 85)
            send_beat(OP_TICK, 2'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom));
        else if (pick < 92)
            send_beat(OP_STOP, 2'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom));
        else
        begin
            counted = 1'b0;
            send_beat(OP_UNUSED, 2'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        int  done;
        bit  counted;
        bit  paused;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed, reset register values (max 100, gain 0.5) ---
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);   // all-zero state
        send_beat(OP_SET, 2'd0, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_beat(OP_SET, 2'd1, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_beat(OP_SET, 2'd2, 8'h00, 8'h80, 1'b1, 1'b0);    // reversed zero PWM
        send_beat(OP_SET, 2'd3, 8'hFF, 8'hFF, 1'b1, 1'b1);    // no such robot
        send_beat(OP_UNUSED, 2'd3, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
        send_beat(OP_TICK, 2'd3, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_beat(OP_SET, 2'd2, 8'h01, 8'hFE, 1'b1, 1'b1);
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
        send_beat(OP_STOP, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);   // zeros after stop
        send_beat(OP_SET, 2'd0, 8'hAA, 8'h55, 1'b0, 1'b1);
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);

        // gain of one: speeds land on the targets, full scale both ways
        wait_idle();
        program_regs(1023, 65536, 0, 1'b1);
        send_beat(OP_SET, 2'd0, 8'hFF, 8'hFF, 1'b0, 1'b1);
        send_beat(OP_SET, 2'd1, 8'hFF, 8'h01, 1'b1, 1'b0);
        send_beat(OP_SET, 2'd2, 8'h80, 8'h00, 1'b0, 1'b1);
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);

        // widest deadband: full speed sits exactly on it and survives,
        // anything smaller collapses to zero
        wait_idle();
        program_regs(1023, 65536, SPEED_LIMIT, 1'b0);
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
        send_beat(OP_SET, 2'd0, 8'hFE, 8'h00, 1'b0, 1'b0);
        send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
        send_beat(OP_STOP, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);

        // --- random phases, one register setting each ---
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: program_regs(1023, 65536, 0, 1'b1);
                1: program_regs(0, 0, 0, 1'b0);              // speeds frozen
                2: program_regs(1023, 131071, 0, 1'b1);      // overshoot, saturation
                3: program_regs($urandom_range(1023), $urandom_range(65536),
                                $urandom_range(1 << 22), 1'($urandom));
                4: program_regs(1023, 1, $urandom_range(1 << 16), 1'b0);
                default: program_regs($urandom_range(1023), $urandom_range(131071),
                                      $urandom_range(1 << 21), 1'($urandom));
            endcase
            calm = (p == 3);   // a whole phase with no idling on either side
            if (p == 2)
            begin
                // output blocked for a long stretch while ticks keep coming
                @(posedge clk);
                hold_reqs++;
                repeat (4)
                    send_beat(OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
            end
            done   = 0;
            paused = 1'b0;
            while (done < ITEMS_PER_PHASE)
            begin
                if (p == 4 && !paused && done == ITEMS_PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    wait_idle();
                end
                random_item(counted);
                if (counted)
                    done++;
            end
        end

        wait_idle();
        @(negedge clk);
        end_of_test <= 1'b1;
        @(negedge clk);

        $display("Ran directed extremes plus %0d register settings: %0d ticks, %0d robot commands checked.",
                 PHASES, ticks_seen, cmds_checked);
        $display("Exercised deadband edge, gain above one, ignored beats, stop, long output stall.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- wheel_speed_smoother.f -----
+incdir+rtl
rtl/wss_pkg.sv
rtl/wss_ctrl.sv
rtl/wss_datapath.sv
rtl/wheel_speed_smoother.sv
rtl/wss_checker.sv
sim/wss_checker.sv
sim/tb_top.sv
